// ----- rtl/rwa_pkg.sv -----
// shared types and constants for the runway request arbiter
// no dependencies; used by every module of the block

package rwa_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 16;
    localparam int TIME_W      = 32;
    localparam int THR_CNT_W   = 7;
    localparam int THR_WAIT_W  = 16;
    localparam int FLD_CNT_W   = 7;

    localparam logic [THR_CNT_W-1:0]  TAKE_CNT_RST  = THR_CNT_W'(3);
    localparam logic [THR_WAIT_W-1:0] TAKE_WAIT_RST = THR_WAIT_W'(10);
    localparam logic [THR_WAIT_W-1:0] LAND_WAIT_RST = THR_WAIT_W'(20);

    typedef enum logic [2:0] {
        REQ_TICK  = 3'd0,
        REQ_LAND  = 3'd1,
        REQ_TAKE  = 3'd2,
        REQ_EMERG = 3'd3,
        REQ_SERVE = 3'd4
    } req_kind_t;

    typedef enum logic [1:0] {
        SRC_NONE  = 2'd0,
        SRC_EMERG = 2'd1,
        SRC_LAND  = 2'd2,
        SRC_TAKE  = 2'd3
    } src_t;

    typedef enum logic [1:0] {
        CFG_TAKE_CNT  = 2'd0,
        CFG_TAKE_WAIT = 2'd1,
        CFG_LAND_WAIT = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [2:0]      req_type;
        logic [ID_W-1:0] plane_id;
    } in_item_t;

    typedef struct packed {
        logic                 granted;
        logic [1:0]           granted_source;
        logic [ID_W-1:0]      granted_plane_id;
        logic                 request_dropped;
        logic [FLD_CNT_W-1:0] emergency_count;
        logic [FLD_CNT_W-1:0] landing_count;
        logic [FLD_CNT_W-1:0] takeoff_count;
    } out_item_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] arrival;
    } slot_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        slot_t            head;
    } qstat_t;

    typedef struct packed {
        logic push;
        logic pop;
    } qctl_t;

endpackage

// ----- rtl/rwa_queue.sv -----
// one circular request queue: slot memory, pointers, count and a head slot
// depends on rwa_pkg

module rwa_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  rwa_pkg::qctl_t ctl,
    input  rwa_pkg::slot_t wr_slot,
    output rwa_pkg::qstat_t stat
);

    rwa_pkg::slot_t mem [rwa_pkg::QUEUE_DEPTH];

    logic [rwa_pkg::PTR_W-1:0] head_reg, head_next;
    logic [rwa_pkg::PTR_W-1:0] tail_reg, tail_next;
    logic [rwa_pkg::CNT_W-1:0] count_reg, count_next;
    rwa_pkg::slot_t            rd_data_reg;
    rwa_pkg::slot_t            byp_data_reg;
    logic                      byp_reg, byp_next;

    function automatic logic [rwa_pkg::PTR_W-1:0] wrap_inc(input logic [rwa_pkg::PTR_W-1:0] p);
        logic [rwa_pkg::PTR_W-1:0] r;
        if (p == rwa_pkg::PTR_W'(rwa_pkg::QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    always_comb
    begin
        head_next  = ctl.pop ? wrap_inc(head_reg) : head_reg;
        tail_next  = ctl.push ? wrap_inc(tail_reg) : tail_reg;
        count_next = count_reg + rwa_pkg::CNT_W'(ctl.push) - rwa_pkg::CNT_W'(ctl.pop);
        // a push into the slot the head will read next must bypass the memory
        byp_next   = ctl.push && (tail_reg == head_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            byp_reg   <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            byp_reg   <= byp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[tail_reg] <= wr_slot;
        end
        rd_data_reg  <= mem[head_next];
        byp_data_reg <= wr_slot;
    end

    assign stat.count = count_reg;
    assign stat.head  = byp_reg ? byp_data_reg : rd_data_reg;

endmodule

// ----- rtl/rwa_sched.sv -----
// request decode and grant decision for one item against the queue heads
// depends on rwa_pkg

module rwa_sched (
    input  logic                              go,
    input  rwa_pkg::in_item_t                 item,
    input  rwa_pkg::qstat_t                   emerg_stat,
    input  rwa_pkg::qstat_t                   land_stat,
    input  rwa_pkg::qstat_t                   take_stat,
    input  logic [rwa_pkg::TIME_W-1:0]        now_ticks,
    input  logic [rwa_pkg::THR_CNT_W-1:0]     take_cnt_thr,
    input  logic [rwa_pkg::THR_WAIT_W-1:0]    take_wait_thr,
    input  logic [rwa_pkg::THR_WAIT_W-1:0]    land_wait_thr,
    output rwa_pkg::qctl_t                    emerg_ctl,
    output rwa_pkg::qctl_t                    land_ctl,
    output rwa_pkg::qctl_t                    take_ctl,
    output logic                              tick,
    output rwa_pkg::out_item_t                result
);

    logic                        e_ne, l_ne, t_ne;
    logic                        e_full, l_full, t_full;
    logic [rwa_pkg::TIME_W-1:0]  take_wait, land_wait;
    logic                        take_first;
    logic                        serve;
    rwa_pkg::qctl_t              e_c, l_c, t_c;
    logic                        dropped;
    rwa_pkg::src_t               src;
    logic [rwa_pkg::ID_W-1:0]    gid;

    always_comb
    begin
        e_ne   = emerg_stat.count != '0;
        l_ne   = land_stat.count != '0;
        t_ne   = take_stat.count != '0;
        e_full = emerg_stat.count == rwa_pkg::CNT_W'(rwa_pkg::QUEUE_DEPTH);
        l_full = land_stat.count == rwa_pkg::CNT_W'(rwa_pkg::QUEUE_DEPTH);
        t_full = take_stat.count == rwa_pkg::CNT_W'(rwa_pkg::QUEUE_DEPTH);

        // waits are modulo the tick counter width
        take_wait = now_ticks - take_stat.head.arrival;
        land_wait = now_ticks - land_stat.head.arrival;

        take_first = t_ne
            && ((32'(take_stat.count) >= 32'(take_cnt_thr))
                || (take_wait >= rwa_pkg::TIME_W'(take_wait_thr)))
            && !(l_ne && (land_wait >= rwa_pkg::TIME_W'(land_wait_thr)));

        e_c     = '0;
        l_c     = '0;
        t_c     = '0;
        dropped = 1'b0;
        serve   = 1'b0;
        tick    = 1'b0;

        case (item.req_type)
            rwa_pkg::REQ_TICK:
            begin
                tick = go;
            end
            rwa_pkg::REQ_LAND:
            begin
                l_c.push = !l_full;
                dropped  = l_full;
            end
            rwa_pkg::REQ_TAKE:
            begin
                t_c.push = !t_full;
                dropped  = t_full;
            end
            rwa_pkg::REQ_EMERG:
            begin
                e_c.push = !e_full;
                dropped  = e_full;
            end
            rwa_pkg::REQ_SERVE:
            begin
                serve = 1'b1;
            end
            default:
            begin
                serve = 1'b0;
            end
        endcase

        e_c.pop = serve && e_ne;
        l_c.pop = serve && !e_ne && l_ne && !take_first;
        t_c.pop = serve && !e_ne && !l_c.pop && t_ne;

        if (e_c.pop)
        begin
            src = rwa_pkg::SRC_EMERG;
            gid = emerg_stat.head.id;
        end
        else if (l_c.pop)
        begin
            src = rwa_pkg::SRC_LAND;
            gid = land_stat.head.id;
        end
        else if (t_c.pop)
        begin
            src = rwa_pkg::SRC_TAKE;
            gid = take_stat.head.id;
        end
        else
        begin
            src = rwa_pkg::SRC_NONE;
            gid = '0;
        end

        emerg_ctl.push = go && e_c.push;
        emerg_ctl.pop  = go && e_c.pop;
        land_ctl.push  = go && l_c.push;
        land_ctl.pop   = go && l_c.pop;
        take_ctl.push  = go && t_c.push;
        take_ctl.pop   = go && t_c.pop;

        result.granted          = src != rwa_pkg::SRC_NONE;
        result.granted_source   = src;
        result.granted_plane_id = gid;
        result.request_dropped  = dropped;
        result.emergency_count  = rwa_pkg::FLD_CNT_W'(emerg_stat.count
            + rwa_pkg::CNT_W'(e_c.push) - rwa_pkg::CNT_W'(e_c.pop));
        result.landing_count    = rwa_pkg::FLD_CNT_W'(land_stat.count
            + rwa_pkg::CNT_W'(l_c.push) - rwa_pkg::CNT_W'(l_c.pop));
        result.takeoff_count    = rwa_pkg::FLD_CNT_W'(take_stat.count
            + rwa_pkg::CNT_W'(t_c.push) - rwa_pkg::CNT_W'(t_c.pop));
    end

endmodule

// ----- rtl/runway_request_arbiter.sv -----
// top level of the runway request arbiter: input stage, three queues,
// grant decision, result register and threshold registers
// depends on rwa_pkg, rwa_queue, rwa_sched
//
// usage:
//   request channel (req_valid, req_stall, req_data): one request per
//   accepted item: tick, landing, takeoff or emergency request, or serve.
//   result channel (res_valid, res_stall, res_data): exactly one result per
//   request, in order, carrying grant, drop flag and queue occupancies.
//   config channel (cfg_valid, cfg_ready, cfg_index, cfg_data): writes the
//   three thresholds; cfg_ready is always high, index 3 is ignored.
// path: an accepted request is registered in the input register, and its
//   result then in the result register, which drives res_valid.
// throughput: one request per cycle while res_stall is low; the head slot
//   of each queue is kept in a register refetched from the slot memory on
//   every pop, so grants can follow each other in consecutive cycles.
// reset: queues empty, tick counter zero, thresholds 3, 10 and 20; the
//   slot memories are not cleared and need no clearing time.
// stall: a stalled result holds; the input stage still empties into the
//   result register when it is free and stalls the request side otherwise.

module runway_request_arbiter (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  rwa_pkg::in_item_t                 req_data,
    output logic                              res_valid,
    input  logic                              res_stall,
    output rwa_pkg::out_item_t                res_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [rwa_pkg::THR_WAIT_W-1:0]    cfg_data
);

    logic                              s1_valid_reg, s1_valid_next;
    rwa_pkg::in_item_t                 s1_item_reg;
    logic                              res_valid_reg, res_valid_next;
    rwa_pkg::out_item_t                res_item_reg;
    logic [rwa_pkg::TIME_W-1:0]        now_reg, now_next;
    logic [rwa_pkg::THR_CNT_W-1:0]     take_cnt_reg;
    logic [rwa_pkg::THR_WAIT_W-1:0]    take_wait_reg;
    logic [rwa_pkg::THR_WAIT_W-1:0]    land_wait_reg;

    logic                  advance;
    logic                  accept;
    logic                  tick;
    rwa_pkg::qctl_t        emerg_ctl, land_ctl, take_ctl;
    rwa_pkg::qstat_t       emerg_stat, land_stat, take_stat;
    rwa_pkg::slot_t        wr_slot;
    rwa_pkg::out_item_t    result;

    assign advance   = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign req_stall = s1_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;
    assign cfg_ready = 1'b1;

    assign wr_slot.id      = s1_item_reg.plane_id;
    assign wr_slot.arrival = now_reg;

    rwa_queue u_emerg_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (emerg_ctl),
        .wr_slot (wr_slot),
        .stat    (emerg_stat)
    );

    rwa_queue u_land_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (land_ctl),
        .wr_slot (wr_slot),
        .stat    (land_stat)
    );

    rwa_queue u_take_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (take_ctl),
        .wr_slot (wr_slot),
        .stat    (take_stat)
    );

    rwa_sched u_sched (
        .go            (advance),
        .item          (s1_item_reg),
        .emerg_stat    (emerg_stat),
        .land_stat     (land_stat),
        .take_stat     (take_stat),
        .now_ticks     (now_reg),
        .take_cnt_thr  (take_cnt_reg),
        .take_wait_thr (take_wait_reg),
        .land_wait_thr (land_wait_reg),
        .emerg_ctl     (emerg_ctl),
        .land_ctl      (land_ctl),
        .take_ctl      (take_ctl),
        .tick          (tick),
        .result        (result)
    );

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        res_valid_next = advance || (res_valid_reg && res_stall);
        now_next       = tick ? now_reg + 1'b1 : now_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            now_reg       <= '0;
            take_cnt_reg  <= rwa_pkg::TAKE_CNT_RST;
            take_wait_reg <= rwa_pkg::TAKE_WAIT_RST;
            land_wait_reg <= rwa_pkg::LAND_WAIT_RST;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            now_reg       <= now_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    rwa_pkg::CFG_TAKE_CNT:
                    begin
                        take_cnt_reg <= cfg_data[rwa_pkg::THR_CNT_W-1:0];
                    end
                    rwa_pkg::CFG_TAKE_WAIT:
                    begin
                        take_wait_reg <= cfg_data;
                    end
                    rwa_pkg::CFG_LAND_WAIT:
                    begin
                        land_wait_reg <= cfg_data;
                    end
                    default:
                    begin
                        take_cnt_reg <= take_cnt_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= req_data;
        end
        if (advance)
        begin
            res_item_reg <= result;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_item_reg;

endmodule

// ----- rtl/rwa_check.sv -----
// port-level checks for the runway request arbiter, bound to the top level
// depends on rwa_pkg and runway_request_arbiter

module rwa_check (
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_stall,
    input rwa_pkg::out_item_t res_data
);

    // a stalled result stays and holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("stalled result changed");

    // a grant always names a source, and no source means no grant
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.granted
            == (res_data.granted_source != rwa_pkg::SRC_NONE)))
        else $error("grant flag and source disagree");

    // one request cannot both be granted and dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res_data.granted && res_data.request_dropped))
        else $error("grant and drop in one result");

    // without a grant the plane id is zero
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.granted |-> res_data.granted_plane_id == '0)
        else $error("plane id without grant");

    // occupancies never exceed the queue depth
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |->
            (32'(res_data.emergency_count) <= rwa_pkg::QUEUE_DEPTH)
            && (32'(res_data.landing_count) <= rwa_pkg::QUEUE_DEPTH)
            && (32'(res_data.takeoff_count) <= rwa_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

endmodule

bind runway_request_arbiter rwa_check u_rwa_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
);
